// File: sv/mpf_pkg.sv
// Shared types and constants of the MPEG-4 picture framer.
`default_nettype none
package mpf_pkg;

  localparam int unsigned LineDepth  = 4;
  localparam int unsigned MaxResults = LineDepth + 1;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);
  localparam int unsigned FillW      = $clog2(LineDepth + 1);

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register index of the picture code register.
  localparam logic [PaddrW-3:0] RegPictureCode = '0;

  localparam logic [7:0] PictureCodeRst = 8'hB6;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       picture_end;
    logic       last_of_run;
  } result_t;

  // All results caused by one input byte, oldest in entry 0.
  typedef struct packed {
    logic [ResCntW-1:0]            count;
    result_t [MaxResults-1:0]      res;
  } bundle_t;

endpackage
`default_nettype wire

// File: sv/mpf_if.sv
// Valid/ready stream interfaces for input bytes and result bytes.
`default_nettype none
interface mpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface mpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       picture_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output picture_end, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input picture_end, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// File: sv/mpf_cfg.sv
// APB register block holding the picture code.
`default_nettype none
module mpf_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mpf_pkg::PaddrW-1:0] paddr,
  input  wire logic [mpf_pkg::PdataW-1:0] pwdata,
  output logic      [mpf_pkg::PdataW-1:0] prdata,
  output logic                            pready,
  output logic      [7:0]                 picture_code_o
);
  import mpf_pkg::*;

  logic [7:0] picture_code_q;
  logic       sel_code;
  logic       wr_en;

  assign pready   = 1'b1;
  assign sel_code = (paddr[PaddrW-1:2] == RegPictureCode);
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      picture_code_q <= PictureCodeRst;
    end else if (wr_en && sel_code) begin
      picture_code_q <= pwdata[7:0];
    end
  end

  assign prdata         = sel_code ? {{(PdataW-8){1'b0}}, picture_code_q} : '0;
  assign picture_code_o = picture_code_q;

endmodule
`default_nettype wire

// File: sv/mpf_core.sv
// Start code scanner and four-byte delay line; builds the results of each byte.
`default_nettype none
module mpf_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             stream_end_i,
  input  wire logic [7:0]       picture_code_i,
  output mpf_pkg::bundle_t      bundle_o
);
  import mpf_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_Z1,
    SCAN_Z2,
    SCAN_PFX
  } scan_e;

  scan_e            scan_q, scan_d;
  logic             vop_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       line_q [LineDepth];

  logic             is_code;
  logic             full;
  logic             flush;
  logic [7:0]       seq [MaxResults];

  always_comb begin
    is_code = 1'b0;
    unique case (scan_q)
      SCAN_IDLE: scan_d = (data_byte_i == 8'h00) ? SCAN_Z1 : SCAN_IDLE;
      SCAN_Z1:   scan_d = (data_byte_i == 8'h00) ? SCAN_Z2 : SCAN_IDLE;
      SCAN_Z2:   scan_d = (data_byte_i == 8'h01) ? SCAN_PFX : SCAN_IDLE;
      SCAN_PFX: begin
        scan_d  = SCAN_IDLE;
        is_code = 1'b1;
      end
      default:   scan_d = SCAN_IDLE;
    endcase
  end

  assign full  = (fill_q == FillW'(LineDepth));
  assign flush = is_code && stream_end_i;

  // Held bytes oldest first, followed by the incoming byte.
  always_comb begin
    for (int k = 0; k < LineDepth; k++) begin
      seq[k] = (FillW'(k) < fill_q) ? line_q[k] : data_byte_i;
    end
    seq[MaxResults-1] = data_byte_i;
  end

  always_comb begin
    if (flush) begin
      fill_d = '0;
    end else if (full) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_comb begin
    if (flush) begin
      bundle_o.count = ResCntW'(fill_q) + 1'b1;
    end else if (full) begin
      bundle_o.count = ResCntW'(1);
    end else begin
      bundle_o.count = '0;
    end
    for (int k = 0; k < MaxResults; k++) begin
      bundle_o.res[k].out_byte    = seq[k];
      bundle_o.res[k].last_of_run = (ResCntW'(k) + 1'b1 == bundle_o.count);
      bundle_o.res[k].picture_end = flush ? bundle_o.res[k].last_of_run
                                          : (is_code && vop_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= SCAN_IDLE;
      vop_q  <= 1'b0;
      fill_q <= '0;
    end else if (accept_i) begin
      scan_q <= scan_d;
      fill_q <= fill_d;
      if (is_code) begin
        vop_q <= (data_byte_i == picture_code_i);
      end
    end
  end

  // Delay line contents are only read below the fill count.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (full) begin
        for (int k = 0; k < LineDepth - 1; k++) begin
          line_q[k] <= line_q[k+1];
        end
        line_q[LineDepth-1] <= data_byte_i;
      end else begin
        line_q[fill_q[$clog2(LineDepth)-1:0]] <= data_byte_i;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/mpf_outq.sv
// Result queue: takes up to five results per byte, hands out one per cycle while the output is ready.
`default_nettype none
module mpf_outq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  mpf_pkg::bundle_t bundle_i,
  output logic             space_o,
  mpf_out_if.source        out_o
);
  import mpf_pkg::*;

  result_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  logic [QCntW-1:0] push_cnt;

  assign space_o  = (cnt_q <= QCntW'(QueueDepth - MaxResults));
  assign pop      = out_o.valid && out_o.ready;
  assign push_cnt = push_i ? QCntW'(bundle_i.count) : '0;

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = mem_q[rd_ptr_q].out_byte;
  assign out_o.picture_end = mem_q[rd_ptr_q].picture_end;
  assign out_o.last_of_run = mem_q[rd_ptr_q].last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + push_cnt - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (push_i && (ResCntW'(k) < bundle_i.count)) begin
        mem_q[wr_ptr_q + QPtrW'(k)] <= bundle_i.res[k];
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/mpeg4_picture_framer.sv
// Top level of the MPEG-4 picture framer.
// The results of a byte enter the result queue at the edge that takes the byte and are
// offered on the output from the queue register, behind any results already queued.
// Throughput: one input byte per cycle while at most three results are queued, since a
// byte may yield up to five; results leave at one per cycle while the output is ready.
// Reset: rst_ni (async, active low) empties the delay line and queue, clears the scanner
// and the picture flag, and sets the picture code to 0xB6.
`default_nettype none
module mpeg4_picture_framer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  mpf_in_if.sink                          in_i,
  mpf_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mpf_pkg::PaddrW-1:0] paddr,
  input  wire logic [mpf_pkg::PdataW-1:0] pwdata,
  output logic      [mpf_pkg::PdataW-1:0] prdata,
  output logic                            pready
);
  import mpf_pkg::*;

  logic       accept;
  logic       space;
  logic [7:0] picture_code;
  bundle_t    bundle;

  // Picture code; the user must write it only while the framer is idle, unenforced.
  mpf_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .picture_code_o (picture_code)
  );

  // A byte is taken whenever the queue has room for the largest possible run of
  // results, so the output side never has to push back on the scanner mid-byte.
  assign in_i.ready = space;
  assign accept     = in_i.valid && in_i.ready;

  // The scanner and the delay line update on every transfer and describe the results
  // the byte causes: none while the line fills, one evicted byte once it is full, or
  // everything held plus the code byte on a start code at end of stream.
  mpf_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_i.data_byte),
    .stream_end_i   (in_i.stream_end),
    .picture_code_i (picture_code),
    .bundle_o       (bundle)
  );

  // The queue decouples the input from output stalls and serializes multi-result runs.
  mpf_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .bundle_i (bundle),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire
